// ===== sv/tga_pkg.sv =====
// ============================================================================
// TGA decoder package
// Shared types and constants for the TGA true-color decoder core.
// ============================================================================
`default_nettype none

package tga_pkg;

   // Parser phases of the front end.
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_RAW,
      PH_RLEHDR,
      PH_RLEPIX,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // Commands passed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_START,
      OP_PIXEL,
      OP_RUN,
      OP_STATUS
   } op_type;

   // Status codes on the result channel.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TRUNCATED   = 3'd1;
   localparam logic [2:0] ST_COLORMAPPED = 3'd2;
   localparam logic [2:0] ST_BAD_TYPE    = 3'd3;
   localparam logic [2:0] ST_ZERO_SIZE   = 3'd4;
   localparam logic [2:0] ST_BAD_DEPTH   = 3'd5;
   localparam logic [2:0] ST_RLE_OVERRUN = 3'd6;

   // Header layout and field codes.
   localparam logic [4:0] HDR_ID_LEN     = 5'd0;
   localparam logic [4:0] HDR_MAP_TYPE   = 5'd1;
   localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
   localparam logic [4:0] HDR_DEPTH      = 5'd16;
   localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

   localparam logic [7:0] KIND_RAW       = 8'd2;
   localparam logic [7:0] KIND_RLE       = 8'd10;
   localparam logic [7:0] DEPTH_24       = 8'd24;
   localparam logic [7:0] DEPTH_32       = 8'd32;
   localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

   // One command beat through the internal queue.
   typedef struct packed {
      op_type      op;
      logic [31:0] color;    // {alpha, red, green, blue}
      logic [7:0]  count;    // repeat run length, 1 to 128
      logic [2:0]  status;
      logic        done;     // this command completes the image
      logic [15:0] width;
      logic [15:0] height;
      logic [1:0]  origin;   // bit 0 right origin, bit 1 top origin
   } cmd_type;

endpackage

`default_nettype wire

// ===== sv/tga_cmdq.sv =====
// ============================================================================
// TGA command queue
// Two-entry queue of commands between the parser and the pixel writer.
// ============================================================================
`default_nettype none

module tga_cmdq
   import tga_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      cmd_in,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      cmd_out,
   output logic         empty
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign cmd_out = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tga_front.sv =====
// ============================================================================
// TGA byte parser
// Takes file bytes, parses and checks the header, skips the ID field,
// assembles pixels and turns each byte into at most one command.
// ============================================================================
`default_nettype none

module tga_front
   import tga_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,       // byte accepted this cycle
   input  wire logic [7:0]  byte_value,
   input  wire logic        end_of_file,
   output logic             cmd_valid,
   output cmd_type          cmd
);

   phase_type   phase_ff, phase_in, phase_step;
   logic [4:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  id_left_ff, id_left_in;
   logic [7:0]  map_ff, map_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic [1:0]  origin_ff, origin_in;
   logic [31:0] pix_left_ff, pix_left_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  bip_ff, bip_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        repeat_ff, repeat_in;

   logic [31:0] asm_next;
   logic        pix_full;
   logic        d32;
   logic [2:0]  hdr_err;
   logic [7:0]  pkt_len;
   logic        overrun;
   logic [31:0] pl_dec;
   logic [31:0] run_rem;
   logic [1:0]  origin_new;
   logic [31:0] area;
   phase_type   start_ph;
   logic [31:0] color;
   logic        err_now;

   // Pixel assembly from little-endian BGR(A) bytes.
   assign d32 = (depth_ff == DEPTH_32);
   always_comb begin
      case (bip_ff)
         2'd0:    asm_next = {24'd0, byte_value};
         2'd1:    asm_next = asm_ff | {16'd0, byte_value, 8'd0};
         2'd2:    asm_next = asm_ff | {8'd0, byte_value, 16'd0};
         default: asm_next = asm_ff | {byte_value, 24'd0};
      endcase
   end
   assign pix_full = (bip_ff == 2'd3) || ((bip_ff == 2'd2) && !d32);
   assign color    = {(d32 ? asm_next[31:24] : ALPHA_OPAQUE), asm_next[23:0]};

   // Header checks, in priority order.
   always_comb begin
      if (map_ff != 8'd0) begin
         hdr_err = ST_COLORMAPPED;
      end else if ((kind_ff != KIND_RAW) && (kind_ff != KIND_RLE)) begin
         hdr_err = ST_BAD_TYPE;
      end else if ((width_ff == 16'd0) || (height_ff == 16'd0)) begin
         hdr_err = ST_ZERO_SIZE;
      end else if ((depth_ff != DEPTH_24) && (depth_ff != DEPTH_32)) begin
         hdr_err = ST_BAD_DEPTH;
      end else begin
         hdr_err = ST_OK;
      end
   end

   assign origin_new = {byte_value[5], byte_value[4]};
   assign area       = {16'd0, width_ff} * {16'd0, height_ff};
   assign start_ph   = (kind_ff == KIND_RAW) ? PH_RAW : PH_RLEHDR;
   assign pkt_len    = {1'b0, byte_value[6:0]} + 8'd1;
   assign overrun    = ({24'd0, pkt_len} > pix_left_ff);
   assign pl_dec     = pix_left_ff - 32'd1;
   assign run_rem    = pix_left_ff - {24'd0, pkt_left_ff};

   // Next phase.
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (hdr_idx_ff == HDR_DESCRIPTOR) begin
               if (hdr_err != ST_OK) begin
                  phase_step = PH_ERROR;
               end else if (id_left_ff != 8'd0) begin
                  phase_step = PH_IDSKIP;
               end else begin
                  phase_step = start_ph;
               end
            end
         end
         PH_IDSKIP: begin
            if (id_left_ff <= 8'd1) begin
               phase_step = start_ph;
            end
         end
         PH_RAW: begin
            if (pix_full && (pl_dec == 32'd0)) begin
               phase_step = PH_DONE;
            end
         end
         PH_RLEHDR: begin
            phase_step = overrun ? PH_ERROR : PH_RLEPIX;
         end
         PH_RLEPIX: begin
            if (pix_full) begin
               if (repeat_ff) begin
                  phase_step = (run_rem == 32'd0) ? PH_DONE : PH_RLEHDR;
               end else if (pl_dec == 32'd0) begin
                  phase_step = PH_DONE;
               end else if (pkt_left_ff == 8'd1) begin
                  phase_step = PH_RLEHDR;
               end
            end
         end
         default: phase_step = phase_ff;
      endcase
      phase_in = end_of_file ? PH_HEADER : phase_step;
   end

   // Data registers and the command for this byte.
   always_comb begin
      hdr_idx_in  = hdr_idx_ff;
      id_left_in  = id_left_ff;
      map_in      = map_ff;
      kind_in     = kind_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      depth_in    = depth_ff;
      origin_in   = origin_ff;
      pix_left_in = pix_left_ff;
      asm_in      = asm_ff;
      bip_in      = bip_ff;
      pkt_left_in = pkt_left_ff;
      repeat_in   = repeat_ff;
      cmd_valid   = 1'b0;
      cmd         = '0;
      err_now     = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            case (hdr_idx_ff)
               HDR_ID_LEN:     id_left_in = byte_value;
               HDR_MAP_TYPE:   map_in = byte_value;
               HDR_IMG_TYPE:   kind_in = byte_value;
               HDR_WIDTH_LO:   width_in = {8'd0, byte_value};
               HDR_WIDTH_HI:   width_in = {byte_value, width_ff[7:0]};
               HDR_HEIGHT_LO:  height_in = {8'd0, byte_value};
               HDR_HEIGHT_HI:  height_in = {byte_value, height_ff[7:0]};
               HDR_DEPTH:      depth_in = byte_value;
               HDR_DESCRIPTOR: origin_in = origin_new;
               default:        hdr_idx_in = hdr_idx_ff;
            endcase
            if (hdr_idx_ff == HDR_DESCRIPTOR) begin
               hdr_idx_in = 5'd0;
               cmd_valid  = 1'b1;
               if (hdr_err != ST_OK) begin
                  cmd.op     = OP_STATUS;
                  cmd.status = hdr_err;
                  err_now    = 1'b1;
               end else begin
                  pix_left_in = area;
                  bip_in      = 2'd0;
                  cmd.op      = OP_START;
                  cmd.width   = width_ff;
                  cmd.height  = height_ff;
                  cmd.origin  = origin_new;
               end
            end else begin
               hdr_idx_in = hdr_idx_ff + 5'd1;
            end
         end
         PH_IDSKIP: begin
            if (id_left_ff != 8'd0) begin
               id_left_in = id_left_ff - 8'd1;
            end
         end
         PH_RAW: begin
            asm_in = asm_next;
            bip_in = bip_ff + 2'd1;
            if (pix_full) begin
               bip_in      = 2'd0;
               pix_left_in = pl_dec;
               cmd_valid   = 1'b1;
               cmd.op      = OP_PIXEL;
               cmd.color   = color;
               cmd.done    = (pl_dec == 32'd0);
            end
         end
         PH_RLEHDR: begin
            if (overrun) begin
               cmd_valid  = 1'b1;
               cmd.op     = OP_STATUS;
               cmd.status = ST_RLE_OVERRUN;
               err_now    = 1'b1;
            end else begin
               pkt_left_in = pkt_len;
               repeat_in   = byte_value[7];
               bip_in      = 2'd0;
            end
         end
         PH_RLEPIX: begin
            asm_in = asm_next;
            bip_in = bip_ff + 2'd1;
            if (pix_full) begin
               bip_in    = 2'd0;
               cmd_valid = 1'b1;
               cmd.color = color;
               if (repeat_ff) begin
                  cmd.op      = OP_RUN;
                  cmd.count   = pkt_left_ff;
                  cmd.done    = (run_rem == 32'd0);
                  pix_left_in = run_rem;
                  pkt_left_in = 8'd0;
               end else begin
                  cmd.op      = OP_PIXEL;
                  cmd.done    = (pl_dec == 32'd0);
                  pix_left_in = pl_dec;
                  pkt_left_in = pkt_left_ff - 8'd1;
               end
            end
         end
         default: cmd_valid = 1'b0;
      endcase

      // End of file: report truncation unless the image is done or has failed, then clear.
      if (end_of_file) begin
         if (!err_now && (phase_step != PH_DONE) && (phase_step != PH_ERROR)) begin
            cmd_valid  = 1'b1;
            cmd        = '0;
            cmd.op     = OP_STATUS;
            cmd.status = ST_TRUNCATED;
         end
         hdr_idx_in  = 5'd0;
         id_left_in  = 8'd0;
         map_in      = 8'd0;
         kind_in     = 8'd0;
         width_in    = 16'd0;
         height_in   = 16'd0;
         depth_in    = 8'd0;
         origin_in   = 2'd0;
         pix_left_in = 32'd0;
         asm_in      = 32'd0;
         bip_in      = 2'd0;
         pkt_left_in = 8'd0;
         repeat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_idx_ff  <= 5'd0;
         id_left_ff  <= 8'd0;
         map_ff      <= 8'd0;
         kind_ff     <= 8'd0;
         width_ff    <= 16'd0;
         height_ff   <= 16'd0;
         depth_ff    <= 8'd0;
         origin_ff   <= 2'd0;
         pix_left_ff <= 32'd0;
         asm_ff      <= 32'd0;
         bip_ff      <= 2'd0;
         pkt_left_ff <= 8'd0;
         repeat_ff   <= 1'b0;
      end else if (take) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         id_left_ff  <= id_left_in;
         map_ff      <= map_in;
         kind_ff     <= kind_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         origin_ff   <= origin_in;
         pix_left_ff <= pix_left_in;
         asm_ff      <= asm_in;
         bip_ff      <= bip_in;
         pkt_left_ff <= pkt_left_in;
         repeat_ff   <= repeat_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tga_back.sv =====
// ============================================================================
// TGA pixel writer
// Carries out commands: tracks the pixel position, places pixels by origin
// and expands repeat runs into results of up to two pixels.
// ============================================================================
`default_nettype none

module tga_back
   import tga_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  cmd_type           head,
   input  wire logic         q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic [15:0]       rsp_first_col,
   output logic [15:0]       rsp_first_row,
   output logic [15:0]       rsp_second_col,
   output logic [15:0]       rsp_second_row,
   output logic              rsp_second_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_run_last,
   output logic              rsp_image_done
);

   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [1:0]  origin_ff, origin_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [7:0]  used_ff, used_in;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] o_color_ff, o_color_in;
   logic [15:0] o_c1_ff, o_c1_in, o_r1_ff, o_r1_in;
   logic [15:0] o_c2_ff, o_c2_in, o_r2_ff, o_r2_in;
   logic        o_v2_ff, o_v2_in;
   logic [2:0]  o_status_ff, o_status_in;
   logic        o_last_ff, o_last_in;
   logic        o_done_ff, o_done_in;

   logic        slot_free;
   logic        wrap_a, wrap_b;
   logic [15:0] col_a, row_a, col_b, row_b;
   logic [7:0]  run_rem;
   logic        run_two, run_end;

   // Destination column and row for a file position.
   function automatic logic [15:0] dest_col(input logic [15:0] c, input logic [15:0] w,
                                            input logic right);
      dest_col = right ? (w - 16'd1 - c) : c;
   endfunction

   function automatic logic [15:0] dest_row(input logic [15:0] r, input logic [15:0] h,
                                            input logic top);
      dest_row = top ? r : (h - 16'd1 - r);
   endfunction

   // Position after one and after two pixels.
   assign wrap_a = (({1'b0, col_ff} + 17'd1) >= {1'b0, width_ff});
   assign col_a  = wrap_a ? 16'd0 : (col_ff + 16'd1);
   assign row_a  = wrap_a ? (row_ff + 16'd1) : row_ff;
   assign wrap_b = (({1'b0, col_a} + 17'd1) >= {1'b0, width_ff});
   assign col_b  = wrap_b ? 16'd0 : (col_a + 16'd1);
   assign row_b  = wrap_b ? (row_a + 16'd1) : row_a;

   assign run_rem   = head.count - used_ff;
   assign run_two   = (run_rem >= 8'd2);
   assign run_end   = (run_rem <= 8'd2);
   assign slot_free = !out_valid_ff || rsp_pop;

   // Command execution.
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      origin_in    = origin_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      used_in      = used_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      o_color_in   = o_color_ff;
      o_c1_in      = o_c1_ff;
      o_r1_in      = o_r1_ff;
      o_c2_in      = o_c2_ff;
      o_r2_in      = o_r2_ff;
      o_v2_in      = o_v2_ff;
      o_status_in  = o_status_ff;
      o_last_in    = o_last_ff;
      o_done_in    = o_done_ff;
      if (!q_empty) begin
         case (head.op)
            OP_START: begin
               q_pop     = 1'b1;
               width_in  = head.width;
               height_in = head.height;
               origin_in = head.origin;
               col_in    = 16'd0;
               row_in    = 16'd0;
               used_in   = 8'd0;
            end
            OP_STATUS: begin
               if (slot_free) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  o_color_in   = 32'd0;
                  o_c1_in      = 16'd0;
                  o_r1_in      = 16'd0;
                  o_c2_in      = 16'd0;
                  o_r2_in      = 16'd0;
                  o_v2_in      = 1'b0;
                  o_status_in  = head.status;
                  o_last_in    = 1'b1;
                  o_done_in    = 1'b0;
               end
            end
            OP_PIXEL: begin
               if (slot_free) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  o_color_in   = head.color;
                  o_c1_in      = dest_col(col_ff, width_ff, origin_ff[0]);
                  o_r1_in      = dest_row(row_ff, height_ff, origin_ff[1]);
                  o_c2_in      = 16'd0;
                  o_r2_in      = 16'd0;
                  o_v2_in      = 1'b0;
                  o_status_in  = ST_OK;
                  o_last_in    = 1'b1;
                  o_done_in    = head.done;
                  col_in       = col_a;
                  row_in       = row_a;
               end
            end
            OP_RUN: begin
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  o_color_in   = head.color;
                  o_c1_in      = dest_col(col_ff, width_ff, origin_ff[0]);
                  o_r1_in      = dest_row(row_ff, height_ff, origin_ff[1]);
                  o_c2_in      = run_two ? dest_col(col_a, width_ff, origin_ff[0]) : 16'd0;
                  o_r2_in      = run_two ? dest_row(row_a, height_ff, origin_ff[1]) : 16'd0;
                  o_v2_in      = run_two;
                  o_status_in  = ST_OK;
                  o_last_in    = run_end;
                  o_done_in    = run_end && head.done;
                  col_in       = run_two ? col_b : col_a;
                  row_in       = run_two ? row_b : row_a;
                  q_pop        = run_end;
                  used_in      = run_end ? 8'd0 : (used_ff + 8'd2);
               end
            end
            default: q_pop = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         used_ff      <= 8'd0;
         col_ff       <= 16'd0;
         row_ff       <= 16'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         used_ff      <= used_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // Image geometry and result payload.
   always_ff @(posedge clock) begin
      width_ff    <= width_in;
      height_ff   <= height_in;
      origin_ff   <= origin_in;
      o_color_ff  <= o_color_in;
      o_c1_ff     <= o_c1_in;
      o_r1_ff     <= o_r1_in;
      o_c2_ff     <= o_c2_in;
      o_r2_ff     <= o_r2_in;
      o_v2_ff     <= o_v2_in;
      o_status_ff <= o_status_in;
      o_last_ff   <= o_last_in;
      o_done_ff   <= o_done_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_alpha        = o_color_ff[31:24];
   assign rsp_red          = o_color_ff[23:16];
   assign rsp_green        = o_color_ff[15:8];
   assign rsp_blue         = o_color_ff[7:0];
   assign rsp_first_col    = o_c1_ff;
   assign rsp_first_row    = o_r1_ff;
   assign rsp_second_col   = o_c2_ff;
   assign rsp_second_row   = o_r2_ff;
   assign rsp_second_valid = o_v2_ff;
   assign rsp_status       = o_status_ff;
   assign rsp_run_last     = o_last_ff;
   assign rsp_image_done   = o_done_ff;

`ifndef SYNTHESIS
   // A status beat is always alone and never completes an image.
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (o_status_ff != ST_OK)) |-> (o_last_ff && !o_done_ff && !o_v2_ff))
      else $error("status beat carries pixel flags");

   // A run in progress is only ever held by a run command at the queue head.
   a_run_head: assert property (@(posedge clock) disable iff (reset)
      (used_ff != 8'd0) |-> (!q_empty && (head.op == OP_RUN) && (used_ff < head.count)))
      else $error("run progress without a run command at the head");

   // A finished image is only flagged on the last beat of its byte.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && o_done_ff) |-> o_last_ff)
      else $error("image done on a beat that is not the last of its byte");
`endif

endmodule

`default_nettype wire

// ===== sv/tga_rle_truecolor_decoder_core.sv =====
// ============================================================================
// TGA true-color decoder core
// Decodes type 2 and type 10 TGA files of 24 or 32 bits, one byte a beat,
// into RGBA results with destination positions.
// ============================================================================
//
//   channel  direction  handshake        payload
//   req      in         push / full      byte_value, end_of_file
//   rsp      out        pop / empty      color, positions, status, flags
//
// A byte is taken when the command queue has room; each byte gives at most
// one command. The pixel writer takes a start command without giving a
// result, gives one result for a pixel or status command and ceil(N/2)
// results for a repeat run of N pixels, one result a cycle while the result
// register is free. The input stalls once the two-entry queue fills behind
// it. A stall on the result side holds the writer and, through the queue, the
// input. Reset clears the parser, the queue and the result register.
`default_nettype none

module tga_rle_truecolor_decoder_core
   import tga_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [7:0]   req_byte_value,
   input  wire logic         req_end_of_file,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic [15:0]       rsp_first_col,
   output logic [15:0]       rsp_first_row,
   output logic [15:0]       rsp_second_col,
   output logic [15:0]       rsp_second_row,
   output logic              rsp_second_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_run_last,
   output logic              rsp_image_done
);

   logic    take;
   logic    cmd_valid;
   cmd_type cmd;
   logic    q_full, q_empty, q_pop;
   cmd_type head;

   // A byte is accepted whenever the queue has room for its command.
   assign req_full = q_full;
   assign take     = req_push && !q_full;

   tga_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .byte_value  (req_byte_value),
      .end_of_file (req_end_of_file),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   tga_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .push    (take && cmd_valid),
      .cmd_in  (cmd),
      .full    (q_full),
      .pop     (q_pop),
      .cmd_out (head),
      .empty   (q_empty)
   );

   tga_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_first_col    (rsp_first_col),
      .rsp_first_row    (rsp_first_row),
      .rsp_second_col   (rsp_second_col),
      .rsp_second_row   (rsp_second_row),
      .rsp_second_valid (rsp_second_valid),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tga_rle_truecolor_decoder_checker.sv =====
// ============================================================================
// TGA decoder checker
// Watches the byte and result channels of the decoder core, keeps its own
// model of the parser, and compares every result beat field by field.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tga_rle_truecolor_decoder_checker
   import tga_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic        req_full,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_end_of_file,
   input  wire logic        rsp_empty,
   input  wire logic        rsp_pop,
   input  wire logic [7:0]  rsp_red,
   input  wire logic [7:0]  rsp_green,
   input  wire logic [7:0]  rsp_blue,
   input  wire logic [7:0]  rsp_alpha,
   input  wire logic [15:0] rsp_first_col,
   input  wire logic [15:0] rsp_first_row,
   input  wire logic [15:0] rsp_second_col,
   input  wire logic [15:0] rsp_second_row,
   input  wire logic        rsp_second_valid,
   input  wire logic [2:0]  rsp_status,
   input  wire logic        rsp_run_last,
   input  wire logic        rsp_image_done,
   output int               fail_count,
   output int               pending_pixels
);

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [15:0] c1;
      logic [15:0] r1;
      logic [15:0] c2;
      logic [15:0] r2;
      logic        v2;
      logic [2:0]  status;
      logic        last;
      logic        done;
   } pixel_beat;

   pixel_beat pixel_queue[$];

   // Parser state of the model.
   phase_type   m_phase;
   logic [4:0]  m_hdr_idx;
   logic [7:0]  m_id_left;
   logic [7:0]  m_map_type;
   logic [7:0]  m_kind;
   logic [15:0] m_width;
   logic [15:0] m_height;
   logic [7:0]  m_depth;
   logic [1:0]  m_origin;
   logic [15:0] m_col;
   logic [15:0] m_row;
   logic [31:0] m_left;
   logic [31:0] m_pixel;
   logic [1:0]  m_byte_idx;
   logic [7:0]  m_packet_left;
   logic        m_repeat;

   function automatic void clear_parser();
      m_phase = PH_HEADER; m_hdr_idx = 0; m_id_left = 0; m_map_type = 0;
      m_kind = 0; m_width = 0; m_height = 0; m_depth = 0; m_origin = 0;
      m_col = 0; m_row = 0; m_left = 0; m_pixel = 0; m_byte_idx = 0;
      m_packet_left = 0; m_repeat = 0;
   endfunction

   // Destination of the next pixel in file order; steps the file position.
   function automatic void advance_position(output logic [15:0] col,
                                            output logic [15:0] row);
      col = m_origin[0] ? m_width - 16'd1 - m_col : m_col;
      row = m_origin[1] ? m_row : m_height - 16'd1 - m_row;
      m_col++;
      if (m_col >= m_width) begin
         m_col = 0;
         m_row++;
      end
      if (m_left > 0) m_left--;
   endfunction

   // Collects one pixel byte; returns 1 once the pixel is complete.
   function automatic bit gather_pixel(logic [7:0] b);
      int need;
      need = (m_depth == DEPTH_32) ? 4 : 3;
      if (m_byte_idx == 0) m_pixel = 0;
      m_pixel |= 32'(b) << (8 * m_byte_idx);
      m_byte_idx++;
      if (m_byte_idx >= need || m_byte_idx == 0) begin
         m_byte_idx = 0;
         return 1;
      end
      return 0;
   endfunction

   function automatic pixel_beat make_pixel(logic [15:0] c1, logic [15:0] r1,
                                            logic [15:0] c2, logic [15:0] r2,
                                            logic v2);
      pixel_beat p;
      p = '0;
      p.red = m_pixel[23:16];
      p.green = m_pixel[15:8];
      p.blue = m_pixel[7:0];
      p.alpha = (m_depth == DEPTH_32) ? m_pixel[31:24] : ALPHA_OPAQUE;
      p.c1 = c1; p.r1 = r1; p.c2 = c2; p.r2 = r2; p.v2 = v2;
      p.done = (m_left == 0);
      return p;
   endfunction

   function automatic pixel_beat make_status(logic [2:0] code);
      pixel_beat p;
      p = '0;
      p.status = code;
      return p;
   endfunction

   function automatic phase_type data_phase();
      return (m_kind == KIND_RAW) ? PH_RAW : PH_RLEHDR;
   endfunction

   // Works out the result beats that one file byte causes.
   function automatic void decode_byte(logic [7:0] b, logic eof);
      pixel_beat beats[$];
      bit err_now;
      int k;
      logic [15:0] c1, r1, c2, r2;
      logic v2;
      err_now = 0;
      case (m_phase)
         PH_HEADER: begin
            case (m_hdr_idx)
               HDR_ID_LEN:     m_id_left = b;
               HDR_MAP_TYPE:   m_map_type = b;
               HDR_IMG_TYPE:   m_kind = b;
               HDR_WIDTH_LO:   m_width[7:0] = b;
               HDR_WIDTH_HI:   m_width[15:8] = b;
               HDR_HEIGHT_LO:  m_height[7:0] = b;
               HDR_HEIGHT_HI:  m_height[15:8] = b;
               HDR_DEPTH:      m_depth = b;
               HDR_DESCRIPTOR: m_origin = {b[5], b[4]};
               default: ;
            endcase
            if (m_hdr_idx >= HDR_DESCRIPTOR) begin
               m_hdr_idx = 0;
               err_now = 1;
               if (m_map_type != 0) beats.push_back(make_status(ST_COLORMAPPED));
               else if (m_kind != KIND_RAW && m_kind != KIND_RLE)
                  beats.push_back(make_status(ST_BAD_TYPE));
               else if (m_width == 0 || m_height == 0)
                  beats.push_back(make_status(ST_ZERO_SIZE));
               else if (m_depth != DEPTH_24 && m_depth != DEPTH_32)
                  beats.push_back(make_status(ST_BAD_DEPTH));
               else err_now = 0;
               if (err_now) m_phase = PH_ERROR;
               else begin
                  m_left = 32'(m_width) * 32'(m_height);
                  m_col = 0; m_row = 0; m_byte_idx = 0;
                  m_phase = (m_id_left != 0) ? PH_IDSKIP : data_phase();
               end
            end else m_hdr_idx++;
         end
         PH_IDSKIP: begin
            if (m_id_left > 0) m_id_left--;
            if (m_id_left == 0) m_phase = data_phase();
         end
         PH_RAW: begin
            if (gather_pixel(b)) begin
               advance_position(c1, r1);
               beats.push_back(make_pixel(c1, r1, 0, 0, 0));
               if (m_left == 0) m_phase = PH_DONE;
            end
         end
         PH_RLEHDR: begin
            k = int'(b[6:0]) + 1;
            if (k > m_left) begin
               beats.push_back(make_status(ST_RLE_OVERRUN));
               m_phase = PH_ERROR;
               err_now = 1;
            end else begin
               m_packet_left = 8'(k);
               m_repeat = b[7];
               m_byte_idx = 0;
               m_phase = PH_RLEPIX;
            end
         end
         PH_RLEPIX: begin
            if (gather_pixel(b)) begin
               if (m_repeat) begin
                  while (m_packet_left > 0) begin
                     advance_position(c1, r1);
                     m_packet_left--;
                     c2 = 0; r2 = 0; v2 = 0;
                     if (m_packet_left > 0) begin
                        advance_position(c2, r2);
                        m_packet_left--;
                        v2 = 1;
                     end
                     beats.push_back(make_pixel(c1, r1, c2, r2, v2));
                  end
               end else begin
                  advance_position(c1, r1);
                  if (m_packet_left > 0) m_packet_left--;
                  beats.push_back(make_pixel(c1, r1, 0, 0, 0));
               end
               if (m_left == 0) m_phase = PH_DONE;
               else if (m_packet_left == 0) m_phase = PH_RLEHDR;
            end
         end
         default: ;
      endcase
      if (eof) begin
         if (!err_now && m_phase != PH_DONE && m_phase != PH_ERROR) begin
            beats.delete();
            beats.push_back(make_status(ST_TRUNCATED));
         end
         clear_parser();
      end
      if (beats.size() > 0) beats[beats.size() - 1].last = 1;
      foreach (beats[i]) pixel_queue.push_back(beats[i]);
   endfunction

   assign pending_pixels = pixel_queue.size();

   // Prediction on accepted bytes and comparison on accepted result beats.
   always @(posedge clock) begin
      pixel_beat seen;
      pixel_beat want;
      if (reset) begin
         clear_parser();
         pixel_queue.delete();
      end else begin
         if (!rsp_empty && rsp_pop) begin
            seen = {rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_first_col,
                    rsp_first_row, rsp_second_col, rsp_second_row,
                    rsp_second_valid, rsp_status, rsp_run_last, rsp_image_done};
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, seen);
               fail_count++;
            end else begin
               want = pixel_queue.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  $display("%0t: mismatch expected rgba %h %h %h %h pos %0d,%0d %0d,%0d v%0b",
                           $time, want.red, want.green, want.blue, want.alpha,
                           want.c1, want.r1, want.c2, want.r2, want.v2);
                  $display("%0t:   expected status %0d last %0b done %0b",
                           $time, want.status, want.last, want.done);
                  $display("%0t:   actual rgba %h %h %h %h pos %0d,%0d %0d,%0d v%0b",
                           $time, seen.red, seen.green, seen.blue, seen.alpha,
                           seen.c1, seen.r1, seen.c2, seen.r2, seen.v2);
                  $display("%0t:   actual status %0d last %0b done %0b",
                           $time, seen.status, seen.last, seen.done);
               end
            end
         end
         if (req_push && !req_full) decode_byte(req_byte_value, req_end_of_file);
      end
   end

   initial fail_count = 0;

endmodule

`default_nettype wire

// ===== tb/sv/tga_rle_truecolor_decoder_core_tb.sv =====
// ============================================================================
// TGA decoder core testbench
// Feeds headers, raw and run-length files, error cases and noise through the
// decoder under random idling and back pressure; a checker module predicts
// and compares every result beat.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tga_rle_truecolor_decoder_core_tb;
   import tga_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [7:0]  req_byte_value = 0;
   logic        req_end_of_file = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic [15:0] rsp_first_col, rsp_first_row, rsp_second_col, rsp_second_row;
   logic        rsp_second_valid, rsp_run_last, rsp_image_done;
   logic [2:0]  rsp_status;
   int          fail_count;
   int          pending_pixels;

   int  send_idle_pct = 6;
   int  recv_idle_pct = 46;
   bit  recv_hold = 0;
   int  hold_cycles = 0;

   // File being built, one entry per byte.
   logic [7:0] file_bytes[$];

   always #2 clock = ~clock;

   tga_rle_truecolor_decoder_core uut (.*);

   tga_rle_truecolor_decoder_checker checker_i (.*);

   // Receiver: random pops, with one long hold each time it is asked.
   always @(posedge clock) begin
      if (reset) rsp_pop <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_pop <= 0;
      end else if (recv_hold) begin
         hold_cycles <= 300;
         rsp_pop <= 0;
      end else rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Sends one byte and waits until it is accepted; push stays high after.
   task automatic send_byte(logic [7:0] b, logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(posedge clock);
      end
      req_push <= 1;
      req_byte_value <= b;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_full);
   endtask

   // Sends the whole file, then leaves the input idle.
   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      req_push <= 0;
      @(posedge clock);
   endtask

   task automatic build_header(logic [7:0] id_len, logic [7:0] map, logic [7:0] kind,
                               logic [15:0] w, logic [15:0] h, logic [7:0] depth,
                               logic [7:0] desc);
      file_bytes.delete();
      file_bytes.push_back(id_len);
      file_bytes.push_back(map);
      file_bytes.push_back(kind);
      repeat (9) file_bytes.push_back(8'($urandom));
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(h[15:8]);
      file_bytes.push_back(depth);
      file_bytes.push_back(desc);
      repeat (id_len) file_bytes.push_back(8'($urandom));
   endtask

   task automatic add_color(int bpp);
      repeat (bpp) file_bytes.push_back(8'($urandom));
   endtask

   // Builds a well-formed image with random content and optional damage.
   task automatic build_image(logic [7:0] kind, int w, int h, int bpp, bit damage);
      int left, k;
      build_header($urandom_range(3) == 0 ? $urandom_range(4) : 0, 0, kind,
                   16'(w), 16'(h), 8'(bpp * 8), 8'($urandom));
      left = w * h;
      while (left > 0) begin
         if (kind == KIND_RAW) begin
            add_color(bpp);
            left--;
         end else begin
            k = $urandom_range(left > 128 ? 128 : left, 1);
            if ($urandom_range(1)) begin
               file_bytes.push_back(8'h80 | 8'(k - 1));
               add_color(bpp);
            end else begin
               file_bytes.push_back(8'(k - 1));
               repeat (k) add_color(bpp);
            end
            left -= k;
         end
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) file_bytes.push_back(8'($urandom));
      if (damage) begin
         if ($urandom_range(1) && file_bytes.size() > 19)
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 2, 0)];
         else file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
      end
   endtask

   task automatic drain();
      while (pending_pixels != 0) @(posedge clock);
   endtask

   initial begin
      int pick, count;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: minimal images, both types, both depths, three origins.
      build_header(0, 0, KIND_RAW, 1, 1, DEPTH_24, 8'h00);
      add_color(3);
      send_file();
      build_header(2, 0, KIND_RAW, 2, 2, DEPTH_32, 8'h30);
      file_bytes.push_back(8'hff); file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hff); file_bytes.push_back(8'h00);
      repeat (3) add_color(4);
      send_file();
      build_header(0, 0, KIND_RLE, 3, 1, DEPTH_32, 8'h20);
      file_bytes.push_back(8'h00); add_color(4);
      file_bytes.push_back(8'h81); add_color(4);
      send_file();
      // Header errors, overrun and truncation in the header, ID field and pixel data.
      build_header(0, 8'h01, KIND_RAW, 1, 1, DEPTH_24, 0); send_file();
      build_header(0, 0, 8'h03, 1, 1, DEPTH_24, 0); send_file();
      build_header(0, 0, KIND_RAW, 0, 5, DEPTH_24, 0); send_file();
      build_header(0, 0, KIND_RAW, 5, 16'hffff, 8'd16, 0); send_file();
      build_header(0, 0, KIND_RLE, 2, 1, DEPTH_24, 0);
      file_bytes.push_back(8'h82); file_bytes.push_back(8'h55); send_file();
      send_byte(8'h07, 1);
      build_header(6, 0, KIND_RAW, 2, 1, DEPTH_24, 0);
      file_bytes = file_bytes[0:19]; send_file();
      build_header(0, 0, KIND_RAW, 2, 1, DEPTH_24, 0);
      add_color(5); send_file();
      drain();

      // Long receiver hold while long repeat runs fill the block.
      build_header(0, 0, KIND_RLE, 200, 2, DEPTH_24, 8'h10);
      repeat (3) begin
         file_bytes.push_back(8'hff); add_color(3);
      end
      file_bytes.push_back(8'h8f); add_color(3);
      recv_hold <= 1;
      @(posedge clock);
      recv_hold <= 0;
      send_file();
      drain();

      // Random files under three idling profiles.
      for (int phase_sel = 0; phase_sel < 3; phase_sel++) begin
         send_idle_pct = phase_sel == 0 ? 6 : phase_sel == 1 ? 46 : 0;
         recv_idle_pct = phase_sel == 0 ? 46 : phase_sel == 1 ? 6 : 0;
         count = 0;
         while (count < 20) begin
            pick = $urandom_range(99);
            if (pick < 70) build_image($urandom_range(1) ? KIND_RLE : KIND_RAW,
                                       $urandom_range(4, 1), $urandom_range(3, 1),
                                       $urandom_range(4, 3), 0);
            else if (pick < 90) build_image($urandom_range(1) ? KIND_RLE : KIND_RAW,
                                            $urandom_range(3, 1), $urandom_range(2, 1),
                                            $urandom_range(4, 3), 1);
            else begin
               file_bytes.delete();
               repeat ($urandom_range(24, 1)) file_bytes.push_back(8'($urandom));
            end
            send_file();
            count += file_bytes.size();
         end
         drain();
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_pixels == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/tga_pkg.sv
sv/tga_cmdq.sv
sv/tga_front.sv
sv/tga_back.sv
sv/tga_rle_truecolor_decoder_core.sv
tb/sv/tga_rle_truecolor_decoder_checker.sv
tb/sv/tga_rle_truecolor_decoder_core_tb.sv
